// ===== hw/rtl/ppm_pkg.sv =====
// shared types and constants of the ppm decoder
package ppm_pkg;

  localparam int unsigned CHANNEL_COUNT = 8;
  localparam int unsigned CH_W          = 4;
  localparam int unsigned ADDR_W        = 3;
  localparam int unsigned STORE_DEPTH   = 1 << ADDR_W;
  localparam int unsigned WIDTH_W       = 16;
  localparam int unsigned STEP_W        = 10;
  localparam int unsigned DIFF_W        = 15;
  localparam int unsigned PCT_W         = 7;
  localparam int unsigned CNT_W         = 4;
  localparam int unsigned LOST_W        = 8;
  localparam int unsigned CFG_IDX_W     = 1;

  localparam logic [CH_W-1:0]    SYNC_INDEX  = CH_W'(CHANNEL_COUNT);
  localparam logic [CH_W-1:0]    LAST_INDEX  = CH_W'(CHANNEL_COUNT - 1);
  localparam logic [ADDR_W-1:0]  LAST_CONV   = ADDR_W'(6);
  localparam logic [CNT_W-1:0]   DIV_LAST    = CNT_W'(DIFF_W - 1);
  localparam logic [DIFF_W-1:0]  DIFF_MAX    = '1;
  localparam logic [PCT_W-1:0]   FULL_SCALE  = PCT_W'(100);
  localparam logic [PCT_W-1:0]   CENTER      = PCT_W'(50);
  localparam logic [PCT_W-1:0]   SWITCH_LVL  = PCT_W'(80);
  localparam logic [PCT_W-1:0]   LOSS_THR    = PCT_W'(20);
  localparam logic [LOST_W-1:0]  LOST_LIMIT  = LOST_W'(200);
  localparam logic [LOST_W-1:0]  LOST_MAX    = '1;
  localparam logic [WIDTH_W-1:0] MIN_RESET   = WIDTH_W'(1000);
  localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(10);
  localparam logic [STEP_W-1:0]  STEP_ONE    = STEP_W'(1);

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_CAPTURE = 2'd0;
  localparam cmd_t CMD_OVERRUN = 2'd1;
  localparam cmd_t CMD_TICK    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP      = 1'd1;

  typedef struct packed {
    logic                 en;
    logic [ADDR_W-1:0]    addr;
    logic [WIDTH_W-1:0]   data;
  } mem_wr_t;

endpackage

// ===== hw/rtl/ppm_ifs.sv =====
// handshake channels of the ppm decoder
interface ppm_in_if;
  logic                            valid;
  logic                            ready;
  ppm_pkg::cmd_t                   command;
  logic [ppm_pkg::WIDTH_W-1:0]     pulse_width;
  modport source (output valid, command, pulse_width, input ready);
  modport sink (input valid, command, pulse_width, output ready);
endinterface

interface ppm_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [ppm_pkg::PCT_W-1:0] roll;
  logic signed [ppm_pkg::PCT_W-1:0] nick;
  logic signed [ppm_pkg::PCT_W-1:0] yaw;
  logic [ppm_pkg::PCT_W-1:0]       throttle;
  logic [ppm_pkg::PCT_W-1:0]       linear_control;
  logic                            enable;
  logic                            aux_switch;
  logic                            signal_lost;
  logic                            frame_complete;
  modport source (output valid, roll, nick, yaw, throttle, linear_control, enable,
                  aux_switch, signal_lost, frame_complete, input ready);
  modport sink (input valid, roll, nick, yaw, throttle, linear_control, enable,
                aux_switch, signal_lost, frame_complete, output ready);
endinterface

interface ppm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ppm_pkg::CFG_IDX_W-1:0]   index;
  logic [ppm_pkg::WIDTH_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/ppm_rc_decoder_failsafe.sv =====
// top level of the ppm radio-control decoder with signal-loss failsafe
// Capture and overrun words produce no result. An update tick reads the seven used
// pulse widths one by one from the pulse memory and converts each in a serial divider
// (one quotient bit per cycle, 15 bits) before its result word is registered. A tick
// during signal loss skips the conversions and goes straight to the output state. The
// result sits in an output register, so capture and overrun words are taken while it
// waits; a further tick holds in its final state until the output register is free.
// Configuration writes are always ready and are not held off while a tick runs.
module ppm_rc_decoder_failsafe
  import ppm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ppm_in_if.sink     in_ch,
  ppm_out_if.source  out_ch,
  ppm_cfg_if.sink    cfg_ch
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]              state_r;
  logic [WIDTH_W-1:0]      min_r;
  logic [STEP_W-1:0]       step_r;
  logic [CH_W-1:0]         ch_idx_r;
  logic                    no_signal_r;
  logic                    complete_r;
  logic [LOST_W-1:0]       lost_r;
  logic [LOST_W-1:0]       lost_nxt;
  logic [ADDR_W-1:0]       conv_r;
  logic [PCT_W-1:0]        roll_r, nick_r, yaw_r, thr_r, lin_r;
  logic                    ena_r, aux_r;
  logic                    out_valid_r;
  logic [PCT_W-1:0]        o_roll_r, o_nick_r, o_yaw_r, o_thr_r, o_lin_r;
  logic                    o_ena_r, o_aux_r, o_lost_r, o_comp_r;

  logic                    in_fire;
  logic                    out_free;
  mem_wr_t                 wr;
  logic                    rd_en;
  logic [WIDTH_W-1:0]      rd_data;
  logic                    div_start;
  logic                    div_done;
  logic [PCT_W-1:0]        pct;
  logic [STEP_W-1:0]       step_eff;
  logic [PCT_W-1:0]        stick;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign step_eff     = (step_r == '0) ? STEP_ONE : step_r;
  assign stick        = pct - CENTER;
  assign lost_nxt     = lost_r + 1'b1;

  always_comb begin
    wr.en   = in_fire && in_ch.command == CMD_CAPTURE && ch_idx_r < SYNC_INDEX;
    wr.addr = ch_idx_r[ADDR_W-1:0];
    wr.data = in_ch.pulse_width;
  end

  assign rd_en     = (state_r == ST_READ);
  assign div_start = (state_r == ST_START);

  ppm_pulse_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (conv_r),
    .rd_data (rd_data)
  );

  ppm_pct_unit u_pct (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .width     (rd_data),
    .min_width (min_r),
    .step      (step_eff),
    .done      (div_done),
    .pct       (pct)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= MIN_RESET;
      step_r <= STEP_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MIN_WIDTH: min_r  <= cfg_ch.data;
        REG_STEP:      step_r <= cfg_ch.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_idx_r    <= '0;
      no_signal_r <= 1'b0;
      complete_r  <= 1'b0;
      lost_r      <= '0;
      conv_r      <= '0;
      roll_r      <= '0;
      nick_r      <= '0;
      yaw_r       <= '0;
      thr_r       <= '0;
      lin_r       <= '0;
      ena_r       <= 1'b0;
      aux_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_ch.command)
              CMD_CAPTURE: begin
                no_signal_r <= 1'b0;
                if (ch_idx_r >= SYNC_INDEX) begin
                  ch_idx_r   <= '0;
                  complete_r <= 1'b0;
                end else begin
                  if (ch_idx_r == LAST_INDEX) begin
                    complete_r <= 1'b1;
                  end
                  ch_idx_r <= ch_idx_r + 1'b1;
                end
              end
              CMD_OVERRUN: begin
                if (ch_idx_r != SYNC_INDEX) begin
                  no_signal_r <= 1'b1;
                  ch_idx_r    <= SYNC_INDEX;
                end
              end
              CMD_TICK: begin
                if (no_signal_r) begin
                  roll_r <= '0;
                  nick_r <= '0;
                  yaw_r  <= '0;
                  if (thr_r > LOSS_THR) begin
                    thr_r <= LOSS_THR;
                  end
                  if (lost_r != LOST_MAX) begin
                    lost_r <= lost_nxt;
                    if (lost_nxt == LOST_LIMIT) begin
                      ena_r <= 1'b0;
                    end
                  end
                  state_r <= ST_OUT;
                end else begin
                  lost_r  <= '0;
                  conv_r  <= '0;
                  state_r <= ST_READ;
                end
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          state_r <= ST_START;
        end
        ST_START: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            case (conv_r)
              3'd0:    roll_r <= stick;
              3'd1:    thr_r  <= pct;
              3'd2:    nick_r <= stick;
              3'd3:    yaw_r  <= stick;
              3'd4:    ena_r  <= pct > SWITCH_LVL;
              3'd5:    lin_r  <= pct;
              3'd6:    aux_r  <= pct > SWITCH_LVL;
              default: ;
            endcase
            if (conv_r == LAST_CONV) begin
              state_r <= ST_OUT;
            end else begin
              conv_r  <= conv_r + 1'b1;
              state_r <= ST_READ;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      o_roll_r <= roll_r;
      o_nick_r <= nick_r;
      o_yaw_r  <= yaw_r;
      o_thr_r  <= thr_r;
      o_lin_r  <= lin_r;
      o_ena_r  <= ena_r;
      o_aux_r  <= aux_r;
      o_lost_r <= no_signal_r;
      o_comp_r <= complete_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.roll           = o_roll_r;
  assign out_ch.nick           = o_nick_r;
  assign out_ch.yaw            = o_yaw_r;
  assign out_ch.throttle       = o_thr_r;
  assign out_ch.linear_control = o_lin_r;
  assign out_ch.enable         = o_ena_r;
  assign out_ch.aux_switch     = o_aux_r;
  assign out_ch.signal_lost    = o_lost_r;
  assign out_ch.frame_complete = o_comp_r;

endmodule

// ===== hw/rtl/ppm_pulse_store.sv =====
// pulse width memory with per-entry valid bits and registered read
module ppm_pulse_store
  import ppm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  mem_wr_t            wr,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [WIDTH_W-1:0] rd_data
);

  logic [WIDTH_W-1:0]     mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid_r;
  logic [WIDTH_W-1:0]     rd_data_r;
  logic                   rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

// ===== hw/rtl/ppm_pct_unit.sv =====
// serial width to percent converter, one quotient bit per cycle
module ppm_pct_unit
  import ppm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [WIDTH_W-1:0] width,
  input  logic [WIDTH_W-1:0] min_width,
  input  logic [STEP_W-1:0]  step,
  output logic               done,
  output logic [PCT_W-1:0]   pct
);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [STEP_W-1:0]  rem_r;
  logic [DIFF_W-1:0]  quo_r;
  logic [DIFF_W-1:0]  dvd_r;
  logic [PCT_W-1:0]   pct_r;

  logic [WIDTH_W-1:0] diff;
  logic [DIFF_W-1:0]  diff_sat;
  logic [STEP_W:0]    trial;
  logic               ge;
  logic [STEP_W:0]    sub;
  logic [DIFF_W-1:0]  quo_nxt;

  always_comb begin
    diff     = width - min_width;
    diff_sat = diff[WIDTH_W-1] ? DIFF_MAX : diff[DIFF_W-1:0];
    trial    = {rem_r, dvd_r[DIFF_W-1]};
    ge       = trial >= {1'b0, step};
    sub      = trial - {1'b0, step};
    quo_nxt  = {quo_r[DIFF_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (width <= min_width) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r && cnt_r == DIV_LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= diff_sat;
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= '0;
      pct_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? sub[STEP_W-1:0] : trial[STEP_W-1:0];
      quo_r <= quo_nxt;
      dvd_r <= {dvd_r[DIFF_W-2:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_LAST) begin
        pct_r <= (quo_nxt > DIFF_W'(FULL_SCALE)) ? FULL_SCALE : quo_nxt[PCT_W-1:0];
      end
    end
  end

  assign done = done_r;
  assign pct  = pct_r;

endmodule
